// ===== hdl/sft_pkg.sv =====
// Shared types and constants for the slotframe table unit.
// No dependencies; the front end, back end and top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package sft_pkg;

  localparam int KEY_W              = 8;
  localparam int SLOT_W             = 16;
  localparam int FLAG_W             = 16;
  localparam int ENTRY_W            = KEY_W + SLOT_W + FLAG_W;
  localparam int KIND_W             = 2;
  localparam int CNT_OUT_W          = 4;
  localparam int IN_DATA_W          = 40;
  localparam int OUT_DATA_W         = 40;
  localparam int DEFAULT_TABLE_DEPTH = 8;
  localparam int QUEUE_DEPTH        = 2;

  // Operation codes, equal to the kind field values
  typedef enum logic [KIND_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slots;
    logic [FLAG_W-1:0] flags;
  } cmd_t;

  typedef struct packed {
    logic                 ok;
    logic [SLOT_W-1:0]    slots;
    logic [FLAG_W-1:0]    flags;
    logic [CNT_OUT_W-1:0] count;
  } res_t;

  // Table entry as held in the RAM: key in the low bits
  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [SLOT_W-1:0] slots;
    logic [KEY_W-1:0]  key;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_ACT,
    BK_DLRD,
    BK_DLWR,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

// ===== hdl/sft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/sft_front.sv =====
// Front end: accepts input transactions, decodes the kind into an operation
// and holds them in a short command queue. Depends on sft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sft_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sft_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [sft_pkg::KEY_W-1:0]     in_key,
  input  wire logic [sft_pkg::SLOT_W-1:0]    in_slots,
  input  wire logic [sft_pkg::FLAG_W-1:0]    in_flags,
  output logic                               q_valid,
  input  wire logic                          q_ready,
  output sft_pkg::cmd_t                      q_cmd
);
  import sft_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(QUEUE_DEPTH);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  cmd_t             dec_cmd;
  logic             push;
  logic             pop;

  // Kind values map one to one onto the operation codes
  always_comb begin
    dec_cmd.key   = in_key;
    dec_cmd.slots = in_slots;
    dec_cmd.flags = in_flags;
    dec_cmd.op    = op_t'(in_kind);
  end

  assign in_ready = (cnt_r != FULL_C);
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sft_back.sv =====
// Back end: scans the entry RAM for the key, applies update, delete or lookup,
// and holds the result in an output register. Depends on sft_pkg, sft_ram.
`timescale 1ns / 1ps
`default_nettype none

module sft_back #(
  parameter int TABLE_DEPTH = sft_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire sft_pkg::cmd_t q_cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output sft_pkg::res_t      res
);
  import sft_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  bk_state_t        state_r, state_nxt;
  cmd_t             cmd_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] issue_idx_r;
  logic [IDX_W-1:0] pend_idx_r;
  logic             pend_valid_r;
  logic [IDX_W-1:0] pos_r;
  logic             found_r;
  logic             ok_r;
  logic [SLOT_W-1:0] slots_r;
  logic [FLAG_W-1:0] flags_r;
  logic             res_valid_r;
  res_t             res_r;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic             scan_hit;
  logic             scan_miss;
  logic             issue_go;
  logic             has_room;
  logic             load_res;
  logic [CNT_W-1:0] fill_dec;
  logic [CNT_W+CNT_OUT_W-1:0] fill_ext;

  sft_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read data is registered in the RAM; pend_* tracks the entry in flight
  assign scan_hit  = (state_r == BK_SCAN) && pend_valid_r && (ram_rdata.key == cmd_r.key);
  assign scan_miss = (state_r == BK_SCAN) && !pend_valid_r && (issue_idx_r >= fill_r);
  assign issue_go  = (state_r == BK_SCAN) && (issue_idx_r < fill_r) && !scan_hit;
  assign has_room  = (fill_r < DEPTH_C);
  assign load_res  = (state_r == BK_DONE) && (!res_valid_r || res_ready);
  assign fill_dec  = fill_r - 1'b1;
  assign fill_ext  = {{CNT_OUT_W{1'b0}}, fill_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid) state_nxt = BK_SCAN;
      BK_SCAN: if (scan_hit || scan_miss) state_nxt = BK_ACT;
      BK_ACT: begin
        if (cmd_r.op == OP_DELETE && found_r) state_nxt = BK_DLRD;
        else state_nxt = BK_DONE;
      end
      BK_DLRD: state_nxt = BK_DLWR;
      BK_DLWR: state_nxt = BK_DONE;
      BK_DONE: if (load_res) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // RAM control and queue pop
  always_comb begin
    q_ready   = (state_r == BK_IDLE);
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = '{flags: cmd_r.flags, slots: cmd_r.slots, key: cmd_r.key};
    ram_raddr = issue_idx_r[IDX_W-1:0];
    unique case (state_r)
      BK_ACT: begin
        if (cmd_r.op == OP_UPDATE) begin
          if (found_r) begin
            ram_we = 1'b1;
          end else if (has_room) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[IDX_W-1:0];
          end
        end
      end
      BK_DLRD: ram_raddr = fill_dec[IDX_W-1:0];
      BK_DLWR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  // Command and result payload
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && q_valid) begin
      cmd_r   <= q_cmd;
      slots_r <= '0;
      flags_r <= '0;
    end
    if (issue_go) begin
      pend_idx_r <= issue_idx_r[IDX_W-1:0];
    end
    if (scan_hit) begin
      pos_r <= pend_idx_r;
      if (cmd_r.op == OP_LOOKUP) begin
        slots_r <= ram_rdata.slots;
        flags_r <= ram_rdata.flags;
      end
    end
    if (state_r == BK_ACT) begin
      unique case (cmd_r.op)
        OP_UPDATE: ok_r <= found_r || has_room;
        OP_DELETE: ok_r <= found_r;
        OP_LOOKUP: ok_r <= found_r;
        OP_NONE:   ok_r <= 1'b0;
      endcase
    end
    if (load_res) begin
      res_r <= '{ok: ok_r, slots: slots_r, flags: flags_r,
                 count: fill_ext[CNT_OUT_W-1:0]};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      fill_r       <= '0;
      issue_idx_r  <= '0;
      pend_valid_r <= 1'b0;
      found_r      <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_IDLE && q_valid) begin
        issue_idx_r  <= '0;
        pend_valid_r <= 1'b0;
        found_r      <= 1'b0;
      end else if (state_r == BK_SCAN) begin
        pend_valid_r <= issue_go;
        if (issue_go) begin
          issue_idx_r <= issue_idx_r + 1'b1;
        end
        if (scan_hit) begin
          found_r <= 1'b1;
        end
      end
      if (state_r == BK_ACT && cmd_r.op == OP_UPDATE && !found_r && has_room) begin
        fill_r <= fill_r + 1'b1;
      end
      if (state_r == BK_DLWR) begin
        fill_r <= fill_dec;
      end
      if (load_res) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== hdl/slotframe_table_unit.sv =====
// Top level of the slotframe table unit: stream ports, front end and back end.
// Depends on sft_pkg, sft_front, sft_back (which holds sft_ram).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                      Carries
// -------   ---  -------------------------  ---------------------------------
// in_       in   tvalid tready tdata tuser  table command (update/delete/lookup)
// out_      out  tvalid tready tdata tuser  one result per command
//
// Timing: after a command leaves the queue, the back end compares one entry
// per cycle on the single RAM read port, then does write-back and result
// load; a successful delete also fetches the last entry and moves it into
// the freed position.
// Reset: rst_n is synchronous, active low; the table is empty afterwards.
// Stalls: a two-deep command queue keeps accepting while the back end works,
// and the result register frees the back end once out_ is taken.

module slotframe_table_unit #(
  parameter int TABLE_DEPTH = sft_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] frame_id, [23:8] slot_count, [39:24] frame_flags
  input  wire logic [sft_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] kind
  input  wire logic [sft_pkg::KIND_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] found_slots, [31:16] found_flags, [35:32] entry_count, rest zero
  output logic      [sft_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] ok
  output logic                                   out_tuser
);
  import sft_pkg::*;

  localparam int PAD_W = OUT_DATA_W - SLOT_W - FLAG_W - CNT_OUT_W;

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;
  res_t res;

  // Unpack the input transaction; the front end decodes the kind
  sft_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_key   (in_tdata[KEY_W-1:0]),
    .in_slots (in_tdata[KEY_W +: SLOT_W]),
    .in_flags (in_tdata[KEY_W+SLOT_W +: FLAG_W]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  // Scan, edit and result register
  sft_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result transaction, zero fill to a whole byte
  assign out_tdata = {{PAD_W{1'b0}}, res.count, res.flags, res.slots};
  assign out_tuser = res.ok;

endmodule

`default_nettype wire
